@@ rtl/b64ld_pkg.sv @@
// ----------------------------------------------------------------------------
// b64ld_pkg
// Shared types, codes and the alphabet lookup for the line-based Base64
// decoder.
// ----------------------------------------------------------------------------
package b64ld_pkg;

  localparam int CharW   = 8;
  localparam int SymW    = 6;
  localparam int AccW    = 12;
  localparam int HeldW   = 4;
  localparam int StatusW = 3;

  localparam logic [CharW-1:0] CHAR_PAD  = 8'h3D;  // '='
  localparam logic [CharW-1:0] CHAR_DASH = 8'h2D;  // '-'

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_BAD_PAD   = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_AFTER_PAD = 3'd4,
    ST_HALTED    = 3'd5
  } status_t;

  typedef struct packed {
    logic            ok;
    logic [SymW-1:0] value;
  } sym_t;

  function automatic sym_t sym_lookup(input logic [CharW-1:0] c);
    sym_t s;
    s.ok    = 1'b1;
    s.value = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = SymW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = SymW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = SymW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

@@ rtl/base64_line_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_line_decoder
// Line-oriented Base64 decoder: one character in, one result out.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                tuser        tlast
// s_axis   in   [7:0] char_code                      -            line_end
// m_axis   out  [7:0] data_byte, [10:8] status,      [0] byte_    -
//               [15:11] zero                         valid
//
// One character per cycle while m_axis is not stalled; the result appears in the output
// register in the cycle after the input transfer. Lookup, accumulate and line checks sit
// between the line state registers and the output register.
// The input is stalled only while a result waits and m_axis_tready is low.
// rst is synchronous; after an error, including data after the padded end of stream,
// every later result reads halted until reset.
// ----------------------------------------------------------------------------
module base64_line_decoder (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [b64ld_pkg::CharW-1:0]  s_axis_tdata,   // [7:0] char_code
  input  logic                         s_axis_tlast,   // line_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [7:0] data_byte, [10:8] status
  output logic                         m_axis_tuser    // [0] byte_valid
);
  import b64ld_pkg::*;

  logic [AccW-1:0]  acc, acc_next;
  logic [HeldW-1:0] held, held_next;
  logic [1:0]       len, len_next;
  logic             line_start, line_start_next;
  logic             skipping, skipping_next;
  logic             line_pad, line_pad_next;
  logic             pad_seen, pad_seen_next;
  logic             finished, finished_next;
  logic             halted, halted_next;

  logic             out_valid_byte, out_valid_byte_next;
  logic [CharW-1:0] out_byte, out_byte_next;
  status_t          out_status, out_status_next;

  logic             accept;
  sym_t             sym;
  logic [AccW-1:0]  acc_shift;
  logic [HeldW-1:0] held_sum;
  logic             is_dash;
  logic             is_pad;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {5'b0, out_status, out_byte};
  assign m_axis_tuser  = out_valid_byte;

  assign sym       = sym_lookup(s_axis_tdata);
  assign is_dash   = (s_axis_tdata == CHAR_DASH);
  assign is_pad    = (s_axis_tdata == CHAR_PAD);
  assign acc_shift = {acc[AccW-SymW-1:0], sym.value};
  assign held_sum  = held + HeldW'(SymW);

  always_comb begin
    acc_next            = acc;
    held_next           = held;
    len_next            = len;
    line_start_next     = line_start;
    skipping_next       = skipping;
    line_pad_next       = line_pad;
    pad_seen_next       = pad_seen;
    finished_next       = finished;
    halted_next         = halted;
    out_valid_byte_next = 1'b0;
    out_byte_next       = '0;
    out_status_next     = ST_OK;
    if (halted) begin
      out_status_next = ST_HALTED;
    end else if (line_start && !is_dash && finished) begin
      line_start_next = 1'b0;
      halted_next     = 1'b1;
      out_status_next = ST_AFTER_PAD;
    end else if (skipping || (line_start && is_dash)) begin
      line_start_next = s_axis_tlast;
      skipping_next   = !s_axis_tlast;
      if (s_axis_tlast) begin
        acc_next      = '0;
        held_next     = '0;
        len_next      = '0;
        line_pad_next = 1'b0;
      end
    end else begin
      line_start_next = 1'b0;
      len_next        = len + 2'd1;
      if (is_pad) begin
        line_pad_next = 1'b1;
        pad_seen_next = 1'b1;
      end else if (line_pad) begin
        halted_next     = 1'b1;
        out_status_next = ST_BAD_PAD;
      end else if (!sym.ok) begin
        halted_next     = 1'b1;
        out_status_next = ST_INVALID;
      end else begin
        acc_next = acc_shift;
        if (held_sum >= HeldW'(CharW)) begin
          held_next           = held_sum - HeldW'(CharW);
          out_valid_byte_next = 1'b1;
          unique case (held_sum)
            4'd12:   out_byte_next = acc_shift[11:4];
            4'd10:   out_byte_next = acc_shift[9:2];
            default: out_byte_next = acc_shift[7:0];
          endcase
        end else begin
          held_next = held_sum;
        end
      end
      if (!halted_next && s_axis_tlast) begin
        if (len_next != 2'd0) begin
          halted_next         = 1'b1;
          out_status_next     = ST_BAD_LEN;
          out_valid_byte_next = 1'b0;
          out_byte_next       = '0;
        end else begin
          acc_next        = '0;
          held_next       = '0;
          line_pad_next   = 1'b0;
          skipping_next   = 1'b0;
          line_start_next = 1'b1;
          if (pad_seen_next) begin
            finished_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc           <= '0;
      held          <= '0;
      len           <= '0;
      line_start    <= 1'b1;
      skipping      <= 1'b0;
      line_pad      <= 1'b0;
      pad_seen      <= 1'b0;
      finished      <= 1'b0;
      halted        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        acc        <= acc_next;
        held       <= held_next;
        len        <= len_next;
        line_start <= line_start_next;
        skipping   <= skipping_next;
        line_pad   <= line_pad_next;
        pad_seen   <= pad_seen_next;
        finished   <= finished_next;
        halted     <= halted_next;
      end
      if (accept) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_valid_byte <= out_valid_byte_next;
      out_byte       <= out_byte_next;
      out_status     <= out_status_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

  a_byte_only_ok: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (out_status == ST_OK))
    else $error("decoded byte reported with error status");

  a_held_even: assert property (@(posedge clk) disable iff (rst)
    (held == 4'd0) || (held == 4'd2) || (held == 4'd4) || (held == 4'd6))
    else $error("bit count out of range");

  a_line_start_clean: assert property (@(posedge clk) disable iff (rst)
    line_start |-> (held == 4'd0 && len == 2'd0 && !line_pad && !skipping))
    else $error("line state not cleared at line start");

  a_halted_status: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status == ST_HALTED) |-> halted)
    else $error("halted status without halt flag");
`endif

endmodule

@@ sim/tb_base64_line_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_line_decoder
// Streams text lines into the Base64 line decoder and checks every result
// against a cycle-free predictor of the decode rules. The run covers
// well-formed data lines, comment lines full of arbitrary bytes, four
// handshake phases and one long output stall. It ends in one terminal case
// picked at random: end of stream after padding, an invalid character, a
// stray dash, bad padding, a short line, or an invalid character that also
// ends a short line. A few characters after that confirm the halted state.
// ----------------------------------------------------------------------------
module tb_base64_line_decoder;
  import b64ld_pkg::*;

  typedef struct {
    logic            valid;
    logic [7:0]      data;
    status_t         status;
  } decode_result_t;

  function automatic int b64_value(logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return int'(c) - 'h41;
    if (c >= 8'h61 && c <= 8'h7A) return int'(c) - 'h61 + 26;
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30 + 52;
    if (c == 8'h2B) return 62;
    if (c == 8'h2F) return 63;
    return -1;
  endfunction

  class line_decode_board;
    decode_result_t pending_results[$];
    logic [11:0]    acc;
    logic [3:0]     held;
    logic [1:0]     len_mod4;
    bit             at_start, skipping, line_pad, pad_seen, finished, halted;
    int             errors, chars_in, bytes_out, comment_lines;
    status_t        last_status;

    function new();
      clear_line();
      pad_seen    = 0;
      finished    = 0;
      halted      = 0;
      errors      = 0;
      chars_in    = 0;
      bytes_out   = 0;
      comment_lines = 0;
      last_status = ST_OK;
    endfunction

    function void clear_line();
      acc      = '0;
      held     = '0;
      len_mod4 = '0;
      line_pad = 0;
      skipping = 0;
      at_start = 1;
    endfunction

    function decode_result_t decode_char(logic [7:0] c, bit last);
      decode_result_t r;
      int             v;
      r = '{valid: 1'b0, data: 8'h00, status: ST_OK};
      if (halted) begin
        r.status = ST_HALTED;
        return r;
      end
      if (at_start) begin
        at_start = 0;
        if (c == CHAR_DASH) begin
          skipping = 1;
        end else if (finished) begin
          halted   = 1;
          r.status = ST_AFTER_PAD;
          return r;
        end
      end
      if (skipping) begin
        if (last) begin
          comment_lines++;
          clear_line();
        end
        return r;
      end
      len_mod4 = len_mod4 + 2'd1;
      if (c == CHAR_PAD) begin
        line_pad = 1;
        pad_seen = 1;
      end else if (line_pad) begin
        halted   = 1;
        r.status = ST_BAD_PAD;
        return r;
      end else begin
        v = b64_value(c);
        if (v < 0) begin
          halted   = 1;
          r.status = ST_INVALID;
          return r;
        end
        acc  = {acc[5:0], v[5:0]};
        held = held + 4'd6;
        if (held >= 4'd8) begin
          r.data  = 8'(acc >> (held - 4'd8));
          r.valid = 1'b1;
          held    = held - 4'd8;
        end
      end
      if (last) begin
        if (len_mod4 != 2'd0) begin
          halted = 1;
          r      = '{valid: 1'b0, data: 8'h00, status: ST_BAD_LEN};
          return r;
        end
        clear_line();
        if (pad_seen) finished = 1;
      end
      return r;
    endfunction

    function void note_char(logic [7:0] c, logic last);
      decode_result_t r;
      r = decode_char(c, last);
      pending_results = {pending_results, r};
      chars_in++;
    endfunction

    function void check_result(logic [15:0] tdata, logic tuser);
      decode_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: result with nothing pending: valid=%b data=%02h status=%0d",
                   tuser, tdata[7:0], tdata[10:8]);
        return;
      end
      want = pending_results.pop_front();
      if (tuser !== want.valid || tdata[7:0] !== want.data ||
          tdata[10:8] !== want.status || tdata[15:11] !== 5'd0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: char %0d: want valid=%b data=%02h status=%0d, got valid=%b data=%02h status=%0d pad=%02h",
                   chars_in - pending_results.size(), want.valid, want.data, want.status,
                   tuser, tdata[7:0], tdata[10:8], tdata[15:11]);
      end else begin
        if (want.valid) bytes_out++;
        last_status = want.status;
      end
    endfunction
  endclass

  localparam int ITEMS = 650;
  localparam int LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] char_code
  logic        s_axis_tlast = 1'b0;    // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] data_byte, [10:8] status, [15:11] zero
  logic        m_axis_tuser;           // [0] byte_valid

  line_decode_board board = new();
  string            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  int               sent = 0;
  int               phase = 0;
  int               cycles = 0;
  int               hold_left = 0;
  logic             hold_toggle = 1'b0;
  logic             hold_seen = 1'b0;

  base64_line_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold off for a long stretch on request, otherwise stall per phase
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen     <= hold_toggle;
      hold_left     <= 80;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= ((phase == 2) ? 61 : (phase == 3) ? 7 : 0));
    end
  end

  // sample both sides between edges, where nothing moves
  always @(negedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) board.note_char(s_axis_tdata, s_axis_tlast);
    end
  end

  task automatic send_char(input logic [7:0] c, input bit last);
    bit taken;
    while ($urandom_range(0, 99) < ((phase == 1) ? 61 : (phase == 3) ? 7 : 0)) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = s_axis_tready;
      @(posedge clk);
    end
    sent++;
    phase <= (sent / 160 > 3) ? 3 : sent / 160;
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic send_data_line(input int quads);
    for (int i = 0; i < 4 * quads; i++)
      send_char(alphabet[$urandom_range(0, 63)], i == 4 * quads - 1);
  endtask

  task automatic send_comment_line(input int len);
    send_char(CHAR_DASH, len == 1);
    for (int i = 1; i < len; i++) send_char(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  function automatic logic [7:0] pick_invalid();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (b64_value(c) >= 0 || c == CHAR_PAD) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  initial begin
    int  kind;
    bit  pressure_done;
    pressure_done = 0;
    kind = $urandom_range(0, 5);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_line("AAAA");
    send_line("////");
    send_line("-");
    send_char(CHAR_DASH, 0);
    send_char(CHAR_PAD, 0);
    send_char(8'h00, 0);
    send_char(8'hFF, 1);
    send_line("+/09");
    send_line("TWFu");

    while (sent < ITEMS - 30) begin
      if (!pressure_done && sent >= 100) begin
        hold_toggle   <= ~hold_toggle;
        pressure_done = 1;
      end
      if ($urandom_range(0, 99) < 75) send_data_line($urandom_range(1, 3) + 3 * ($urandom_range(0, 9) == 0));
      else send_comment_line($urandom_range(1, 12));
    end

    case (kind)
      0: begin
        case ($urandom_range(0, 3))
          0: send_line("QQ==");
          1: send_line("QUI=");
          2: send_line("====");
          default: send_line("TWFuTWE=");
        endcase
        send_comment_line($urandom_range(1, 6));
        send_line("TWFu");
      end
      1: begin
        send_char("T", 0);
        send_char("W", 0);
        send_char(pick_invalid(), 0);
        send_char("u", 1);
      end
      2: send_line("TW-u");
      3: send_line("TW=u");
      4: send_line("TW");
      default: begin
        send_char("T", 0);
        send_char("W", 0);
        send_char(pick_invalid(), 1);
      end
    endcase
    send_comment_line(3);
    send_data_line(1);

    s_axis_tvalid <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d characters, %0d decoded bytes and %0d comment lines",
             board.chars_in, board.bytes_out, board.comment_lines);
    $display("Terminal case %0d, last status seen: %s", kind, board.last_status.name());
    if (board.errors == 0 && board.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
